// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the trigger holds, the consequence holds in the following cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: sv/gsa_pkg.sv
// ---------------------------------------------------------------------------
// gsa_pkg
// Types, constants and helpers shared by the group sum and argmax block.
// ---------------------------------------------------------------------------
package gsa_pkg;

  localparam int NUM_BINS  = 16;
  localparam int SUM_WIDTH = 48;
  localparam int REV_W     = 32;
  localparam int KEY_W     = 32;
  localparam int BIN_W     = 4;
  localparam int KEY_SHIFT = 28;
  localparam int OUT_W     = 48;

  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // Candidate that travels down the row of cells during the final scan.
  typedef struct packed {
    logic                 valid;
    logic [BIN_W-1:0]     idx;
    logic [SUM_WIDTH-1:0] total;
  } token_t;

  // Tie order: index modulo 4 first, then the index itself.
  function automatic logic [BIN_W-1:0] tie_rank(input logic [BIN_W-1:0] idx);
    tie_rank = {idx[1:0], idx[3:2]};
  endfunction

endpackage

// File: sv/gsa_cell.sv
// ---------------------------------------------------------------------------
// gsa_cell
// One bin: a saturating accumulator plus one compare stage of the scan row.
// ---------------------------------------------------------------------------
module gsa_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [gsa_pkg::BIN_W-1:0]            cell_idx,
  input  logic                                 add_en,
  input  logic [gsa_pkg::BIN_W-1:0]            add_bin,
  input  logic signed [gsa_pkg::REV_W-1:0]     add_value,
  input  gsa_pkg::token_t                      tok_in,
  output gsa_pkg::token_t                      tok_out
);

  logic [gsa_pkg::SUM_WIDTH-1:0]        total;
  logic [gsa_pkg::SUM_WIDTH-1:0]        total_next;
  logic signed [gsa_pkg::SUM_WIDTH:0]   sum;
  logic                                 own_wins;
  gsa_pkg::token_t                      tok_next;

  // Saturating add: one guard bit shows the overflow.
  always_comb begin
    sum = (gsa_pkg::SUM_WIDTH+1)'($signed(total)) + (gsa_pkg::SUM_WIDTH+1)'(add_value);
    total_next = total;
    if (tok_in.valid) begin
      total_next = '0;
    end else if (add_en && (add_bin == cell_idx)) begin
      if (sum[gsa_pkg::SUM_WIDTH] != sum[gsa_pkg::SUM_WIDTH-1]) begin
        total_next = sum[gsa_pkg::SUM_WIDTH] ? gsa_pkg::SUM_MIN : gsa_pkg::SUM_MAX;
      end else begin
        total_next = sum[gsa_pkg::SUM_WIDTH-1:0];
      end
    end
  end

  // The cell takes over the candidate when its total is larger, or equal
  // with an earlier place in the tie order. The head cell always takes it.
  always_comb begin
    own_wins = (cell_idx == '0) ||
               ($signed(total) > $signed(tok_in.total)) ||
               ((total == tok_in.total) &&
                (gsa_pkg::tie_rank(cell_idx) < gsa_pkg::tie_rank(tok_in.idx)));
    tok_next.valid = tok_in.valid;
    tok_next.idx   = own_wins ? cell_idx : tok_in.idx;
    tok_next.total = own_wins ? total : tok_in.total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total         <= '0;
      tok_out.valid <= 1'b0;
    end else begin
      total         <= total_next;
      tok_out.valid <= tok_next.valid;
    end
    tok_out.idx   <= tok_next.idx;
    tok_out.total <= tok_next.total;
  end

endmodule

// File: sv/group_sum_argmax.sv
// Throughput: one record per cycle while the input is open; after a last record the input
// stalls until the scan candidate has walked the row of NUM_BINS cells and its result has
// been loaded into the output register, which waits while an earlier result is not taken.
// The scan length is set by the cell row, one cell per cycle.
// Reset (rst, synchronous, active high) clears all bin totals and all valid flags.
// ---------------------------------------------------------------------------
// group_sum_argmax
// Streaming group-by sum into 16 saturating bins with an argmax on the last record.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module group_sum_argmax (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] revenue, [63:32] packed_key
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // [3:0] best_group, [51:4] win_total, [55:52] zero
);

  // Request fields of the input channel.
  logic signed [gsa_pkg::REV_W-1:0] revenue;
  logic [gsa_pkg::KEY_W-1:0]        packed_key;
  logic [gsa_pkg::BIN_W-1:0]        req_bin;
  logic                             acc_en;

  // Scan control. The busy flag covers the time from a last record until its
  // result sits in the output register. The pending flag holds the result
  // at the end of the row while an earlier result has not yet been taken.
  logic                             busy;
  logic                             start;
  logic                             pend;
  logic [gsa_pkg::BIN_W-1:0]        pend_idx;
  logic [gsa_pkg::SUM_WIDTH-1:0]    pend_total;
  logic                             out_load;

  logic [gsa_pkg::BIN_W-1:0]        best_group;
  logic [gsa_pkg::OUT_W-1:0]        win_total;

  gsa_pkg::token_t                  tok [gsa_pkg::NUM_BINS+1];
  logic [gsa_pkg::NUM_BINS:0]       tok_valid_vec;

  assign revenue    = s_tdata[gsa_pkg::REV_W-1:0];
  assign packed_key = s_tdata[gsa_pkg::REV_W +: gsa_pkg::KEY_W];
  assign req_bin    = packed_key[gsa_pkg::KEY_SHIFT +: gsa_pkg::BIN_W];

  // The input is closed from a last record until its result is loaded into the output register.
  assign s_tready = !busy;
  assign acc_en   = s_tvalid && s_tready;

  // The head cell is fed an empty candidate that it always replaces.
  assign tok[0] = '{valid: start, idx: '0, total: '0};

  // Each cell holds one bin. A record is offered to every cell and only the
  // matching one adds it. During the scan the candidate moves one cell per
  // cycle, and every cell clears its bin as the candidate passes.
  for (genvar k = 0; k < gsa_pkg::NUM_BINS; k++) begin : g_cell
    gsa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (gsa_pkg::BIN_W'(k)),
      .add_en    (acc_en),
      .add_bin   (req_bin),
      .add_value (revenue),
      .tok_in    (tok[k]),
      .tok_out   (tok[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= gsa_pkg::NUM_BINS; i++) begin
      tok_valid_vec[i] = tok[i].valid;
    end
  end

  assign out_load = pend && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      start    <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      start <= acc_en && s_tlast;
      if (acc_en && s_tlast) begin
        busy <= 1'b1;
      end else if (out_load) begin
        busy <= 1'b0;
      end
      if (tok[gsa_pkg::NUM_BINS].valid) begin
        pend <= 1'b1;
      end else if (out_load) begin
        pend <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (tok[gsa_pkg::NUM_BINS].valid) begin
      pend_idx   <= tok[gsa_pkg::NUM_BINS].idx;
      pend_total <= tok[gsa_pkg::NUM_BINS].total;
    end
    if (out_load) begin
      best_group <= pend_idx;
      // Sign-extend or cut the bin total to the output width.
      win_total  <= gsa_pkg::OUT_W'($signed(pend_total));
    end
  end

  assign m_tdata = {4'b0, win_total, best_group};

  // A last record always starts a scan on the next cycle.
  `ASSERT_NEXT(a_last_starts_scan, s_tvalid && s_tready && s_tlast, busy && start, "last request did not start a scan")
  // Only one candidate is ever in flight along the row.
  `ASSERT_ALWAYS(a_one_token, $onehot0(tok_valid_vec), "more than one scan candidate in flight")
  // A held result belongs to a running scan.
  `ASSERT_ALWAYS(a_pend_busy, !pend || busy, "pending result outside a scan")
  // A new result only appears from a pending one.
  `ASSERT_ALWAYS(a_out_from_pend, !$rose(m_tvalid) || $past(pend), "result appeared without a scan")

endmodule

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb: group sum and argmax stream check
// Streams records into group_sum_argmax with random gaps on both sides. A
// local model of the sixteen saturating bins predicts the winning bin and
// its total on every record marked last. A scoreboard compares each output
// request with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TOTAL_HI = $signed(gsa_pkg::SUM_MAX);
  localparam longint TOTAL_LO = $signed(gsa_pkg::SUM_MIN);
  localparam int LANES = 4;
  localparam int HOLD_CYCLES = 300;

  // One input request as the sender will offer it, with its lead-in gap.
  typedef struct {
    logic [gsa_pkg::REV_W-1:0] rev;
    logic [gsa_pkg::KEY_W-1:0] key;
    logic                      last;
    int                        gap;
  } record_t;

  // One predicted output request.
  typedef struct {
    logic [gsa_pkg::BIN_W-1:0] grp;
    logic [gsa_pkg::OUT_W-1:0] total;
  } winner_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] revenue, [63:32] packed_key
  logic        s_tlast = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // [3:0] best_group, [51:4] win_total, [55:52] zero

  group_sum_argmax uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  record_t                              record_q[$];
  winner_t                              expected_winners[$];
  logic signed [gsa_pkg::SUM_WIDTH-1:0] bin_sum[gsa_pkg::NUM_BINS];
  int                                   err_cnt = 0;
  bit                                   calm = 1'b0;
  int                                   hold_at = -1;
  int                                   hold_left = 0;
  int                                   taken_cnt = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Fold one accepted record into the bins. On a last record, scan the bins
  // lane by lane (index modulo 4) and then by index within a lane, so that
  // with a strict compare the first maximum seen wins the tie, then clear.
  function automatic void fold_record(logic [gsa_pkg::REV_W-1:0] rev,
                                      logic [gsa_pkg::KEY_W-1:0] key, logic last);
    logic [gsa_pkg::BIN_W-1:0]            b;
    longint                               acc;
    logic signed [gsa_pkg::SUM_WIDTH-1:0] top;
    winner_t                              w;
    bit                                   have;
    b = key[gsa_pkg::KEY_SHIFT +: gsa_pkg::BIN_W];
    if (b < gsa_pkg::NUM_BINS) begin
      acc = longint'(bin_sum[b]) + longint'($signed(rev));
      if (acc > TOTAL_HI) acc = TOTAL_HI;
      else if (acc < TOTAL_LO) acc = TOTAL_LO;
      bin_sum[b] = acc[gsa_pkg::SUM_WIDTH-1:0];
    end
    if (!last) return;
    have = 1'b0;
    top = '0;
    w.grp = '0;
    for (int lane = 0; lane < LANES; lane++) begin
      for (int k = lane; k < gsa_pkg::NUM_BINS; k += LANES) begin
        if (!have || bin_sum[k] > top) begin
          top = bin_sum[k];
          w.grp = k[gsa_pkg::BIN_W-1:0];
          have = 1'b1;
        end
      end
    end
    w.total = top[gsa_pkg::OUT_W-1:0];
    expected_winners.push_back(w);
    foreach (bin_sum[i]) bin_sum[i] = '0;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // Key word with the bin in the top nibble and random filler below it.
  function automatic logic [gsa_pkg::KEY_W-1:0] key_in(int b);
    logic [gsa_pkg::KEY_W-1:0] k;
    k = $urandom;
    k[gsa_pkg::KEY_SHIFT +: gsa_pkg::BIN_W] = b[gsa_pkg::BIN_W-1:0];
    return k;
  endfunction

  function automatic logic [gsa_pkg::REV_W-1:0] random_rev();
    case ($urandom_range(0, 5))
      0, 1: return gsa_pkg::REV_W'($signed($urandom_range(0, 4)) - 2);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_record(logic [gsa_pkg::REV_W-1:0] rev, logic [gsa_pkg::KEY_W-1:0] key,
                            logic last);
    record_t r;
    r.rev = rev;
    r.key = key;
    r.last = last;
    r.gap = draw_gap();
    record_q.push_back(r);
  endtask

  // Sender: presents queued requests after each one's gap (none during the hold-off);
  // a request stays up unchanged until the block takes it.
  record_t nxt;
  bit      have_next = 1'b0;
  int      gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_record(s_tdata[31:0], s_tdata[63:32], s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        if (!have_next && record_q.size() > 0) begin
          nxt = record_q.pop_front();
          have_next = 1'b1;
          gap_left = (hold_left > 0) ? 0 : nxt.gap;
        end
        if (have_next && gap_left == 0) begin
          s_tdata <= {nxt.key, nxt.rev};
          s_tlast <= nxt.last;
          s_tvalid <= 1'b1;
          have_next = 1'b0;
        end else begin
          s_tvalid <= 1'b0;
          if (have_next) gap_left--;
        end
      end
    end
  end

  // Long receiver hold-off: once a set number of requests has gone in, the
  // output side refuses everything until the hold counter runs out, so that
  // the result register fills and the block has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      taken_cnt <= 0;
      hold_left <= 0;
    end else begin
      if (s_tvalid && s_tready) taken_cnt <= taken_cnt + 1;
      if (taken_cnt == hold_at && hold_left == 0) hold_left <= HOLD_CYCLES;
      else if (hold_left > 0) hold_left <= hold_left - 1;
    end
  end

  // Receiver and scoreboard. The wait drawn after each request only counts
  // down while a result is being offered, so the stall lands on results.
  int      rcv_wait = 0;
  bit      rcv_calm = 1'b0;
  winner_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_winners.size() == 0) begin
          $error("result with no prediction waiting: group %0d total %h",
                 m_tdata[3:0], m_tdata[51:4]);
          err_cnt++;
        end else begin
          want = expected_winners.pop_front();
          if (m_tdata[3:0] !== want.grp) begin
            $error("best_group: expected %0d, got %0d", want.grp, m_tdata[3:0]);
            err_cnt++;
          end
          if (m_tdata[51:4] !== want.total) begin
            $error("win_total: expected %h, got %h", want.total, m_tdata[51:4]);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 7) == 0) rcv_calm = !rcv_calm;
        rcv_wait = rcv_calm ? 0 : $urandom_range(0, 15);
      end else if (m_tvalid && rcv_wait > 0) begin
        rcv_wait--;
      end
      m_tready <= (hold_left == 0) && (rcv_wait == 0);
    end
  end

  // Stimulus and end of run.
  initial begin
    int len;
    int rnd_cnt;
    foreach (bin_sum[i]) bin_sum[i] = '0;

    // Empty bins: a lone last record with nothing in it reports bin 0.
    add_record(32'd0, 32'h0000_0000, 1'b1);
    // A lone positive record wins with its own bin.
    add_record(32'd5, key_in(7), 1'b1);
    // A lone negative record leaves the zero bins ahead of it.
    add_record(-32'sd5, key_in(3), 1'b1);
    // Equal totals in bins 1, 5 and 4: lane 0 comes first, so bin 4 wins.
    add_record(32'd100, key_in(1), 1'b0);
    add_record(32'd100, key_in(5), 1'b0);
    add_record(32'd100, key_in(4), 1'b0);
    add_record(32'd0, key_in(13), 1'b1);
    // Equal totals within lane 1: the smaller index wins.
    add_record(32'd50, key_in(9), 1'b0);
    add_record(32'd50, key_in(5), 1'b0);
    add_record(32'd0, key_in(6), 1'b1);
    // Revenue extremes.
    add_record(32'h7FFF_FFFF, key_in(15), 1'b0);
    add_record(32'h8000_0000, key_in(14), 1'b0);
    add_record(32'h7FFF_FFFF, key_in(15), 1'b1);
    // Key word extremes, tied between bin 15 and bin 0.
    add_record(32'd7, 32'hFFFF_FFFF, 1'b0);
    add_record(32'd7, 32'h0FFF_FFFF, 1'b1);
    // Tie between lane 2 and lane 3.
    add_record(32'd9, key_in(3), 1'b0);
    add_record(32'd9, key_in(2), 1'b0);
    add_record(32'd0, key_in(11), 1'b1);

    hold_at = record_q.size() + 200;

    // Random data sets, mostly short, a few long, each closed by a last.
    rnd_cnt = 0;
    while (rnd_cnt < 730) begin
      if ($urandom_range(0, 5) == 0) calm = !calm;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        add_record(random_rev(), $urandom, i == len - 1);
      end
      rnd_cnt += len;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (record_q.size() != 0 || have_next || s_tvalid) @(negedge clk);
    while (expected_winners.size() != 0) @(negedge clk);
    repeat (gsa_pkg::NUM_BINS + 8) @(negedge clk);

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
